// ===== rtl/core/cts_pkg.sv =====
// Shared types and constants for the CAN transport segmenter.
package cts_pkg;

  // Protocol control nibbles and frame sizes
  localparam logic [3:0]  FfPci    = 4'h1;
  localparam logic [3:0]  CfPci    = 4'h2;
  localparam logic [11:0] SfMaxLen = 12'd7;
  localparam logic [11:0] FfData   = 12'd6;
  localparam logic [2:0]  FfFill   = 3'd6;
  localparam logic [2:0]  CfFill   = 3'd7;

  // One incoming payload beat
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [11:0] message_length;
  } cts_item_t;

  // One outgoing frame beat
  typedef struct packed {
    logic        valid;
    logic [63:0] frame_bytes;
    logic        message_done;
  } cts_frame_t;

endpackage

// ===== rtl/core/can_transport_segmenter.sv =====
// CAN transport segmenter: ISO-TP style framing of a byte stream into 8-byte CAN frames.
// Takes one payload byte per cycle while the input is not stalled. An accepted byte is
// registered in the input register, then folded into the frame under construction once
// the output register is free or being drained, and a completed frame is then captured
// in the output register. The input stalls only while a registered byte waits behind a
// finished frame that is held in the output register by an output stall. Single, first
// and consecutive frames leave on the beat of the byte that completes them, and
// message_done marks the last frame of a message. A byte that arrives while idle with a
// message length of zero is dropped.
module can_transport_segmenter
  import cts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic [11:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] frame_bytes_o,
  output logic        message_done_o
);

  logic       in_valid_q;
  cts_item_t  item_q;
  logic       advance;
  logic       step;
  cts_frame_t frame;
  logic       out_valid_q;
  logic [63:0] frame_bytes_q;
  logic       message_done_q;

  // Advance when the output register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.payload_byte   <= payload_byte_i;
      item_q.message_length <= message_length_i;
    end
  end

  cts_frame_builder u_builder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .frame_o (frame)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && frame.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && frame.valid) begin
      frame_bytes_q  <= frame.frame_bytes;
      message_done_q <= frame.message_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_bytes_o  = frame_bytes_q;
  assign message_done_o = message_done_q;

`ifndef SYNTHESIS
  a_no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !step)
    else $error("frame builder stepped while output beat was stalled");
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room downstream");
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && frame.valid) |=> out_valid_q)
    else $error("completed frame did not reach the output register");
`endif

endmodule

// ===== rtl/core/cts_frame_builder.sv =====
// Segmentation state and frame assembly for one payload beat per cycle when stepped.
module cts_frame_builder
  import cts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  cts_item_t  item_i,
  output cts_frame_t frame_o
);

  logic [11:0] bytes_taken_q, bytes_taken_d;
  logic [11:0] held_length_q, held_length_d;
  logic [3:0]  seq_q, seq_d;
  logic [63:0] buf_q, buf_d;
  logic [2:0]  fill_q, fill_d;

  logic        idle;
  logic [11:0] len_eff;
  logic [63:0] buf_base;
  logic [63:0] buf_new;
  logic [2:0]  fill_base;
  logic [3:0]  seq_base;
  logic        single;
  logic        first;
  logic [2:0]  pos;
  logic [2:0]  fill_n;
  logic [11:0] taken_n;
  logic        done;
  logic        complete;

  // Build the frame and work out the next state
  always_comb begin
    idle      = (bytes_taken_q == 12'd0);
    len_eff   = idle ? item_i.message_length : held_length_q;
    fill_base = idle ? 3'd0 : fill_q;
    seq_base  = idle ? 4'd0 : seq_q;
    if (!idle) begin
      buf_base = buf_q;
    end else if (item_i.message_length <= SfMaxLen) begin
      buf_base = {52'd0, item_i.message_length};
    end else begin
      buf_base = {48'd0, item_i.message_length[7:0], FfPci, item_i.message_length[11:8]};
    end
    single = (len_eff <= SfMaxLen);
    first  = !single && (bytes_taken_q < FfData);
    if (!single && !first && (fill_base == 3'd0)) begin
      buf_new = {56'd0, CfPci, seq_base};
    end else begin
      buf_new = buf_base;
    end
    // Drop the byte into its lane
    pos = (first ? 3'd2 : 3'd1) + fill_base;
    for (int k = 0; k < 8; k++) begin
      if (pos == 3'(k)) begin
        buf_new[k*8 +: 8] = buf_new[k*8 +: 8] | item_i.payload_byte;
      end
    end
    fill_n  = fill_base + 3'd1;
    taken_n = bytes_taken_q + 12'd1;
    done    = (taken_n == len_eff);
    if (single) begin
      complete = done;
    end else if (first) begin
      complete = (fill_n == FfFill);
    end else begin
      complete = done || (fill_n == CfFill);
    end

    // Hold by default
    bytes_taken_d = bytes_taken_q;
    held_length_d = held_length_q;
    seq_d         = seq_q;
    buf_d         = buf_q;
    fill_d        = fill_q;
    frame_o.valid        = 1'b0;
    frame_o.frame_bytes  = buf_new;
    frame_o.message_done = done;

    if (step_i && !(idle && (item_i.message_length == 12'd0))) begin
      held_length_d = len_eff;
      bytes_taken_d = taken_n;
      seq_d         = seq_base;
      if (complete) begin
        frame_o.valid = 1'b1;
        buf_d  = 64'd0;
        fill_d = 3'd0;
        if (first) begin
          seq_d = 4'd1;
        end else if (!single) begin
          seq_d = seq_base + 4'd1;
        end
        if (done) begin
          bytes_taken_d = 12'd0;
          held_length_d = 12'd0;
          seq_d         = 4'd0;
        end
      end else begin
        buf_d  = buf_new;
        fill_d = fill_n;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_taken_q <= 12'd0;
      held_length_q <= 12'd0;
      seq_q         <= 4'd0;
      buf_q         <= 64'd0;
      fill_q        <= 3'd0;
    end else begin
      bytes_taken_q <= bytes_taken_d;
      held_length_q <= held_length_d;
      seq_q         <= seq_d;
      buf_q         <= buf_d;
      fill_q        <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_active_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_taken_q != 12'd0) |-> (held_length_q != 12'd0 && bytes_taken_q < held_length_q))
    else $error("message in progress without a valid held length");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_taken_q == 12'd0) |-> (fill_q == 3'd0 && seq_q == 4'd0 && held_length_q == 12'd0))
    else $error("idle with stale frame state");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != CfFill)
    else $error("frame fill reached a full frame without emitting");
  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && frame_o.valid && frame_o.message_done) |=> (bytes_taken_q == 12'd0))
    else $error("last frame did not return to idle");
`endif

endmodule
